// ===== hw/rtl/mtep_pkg.sv =====
// Package for the MIDI track event parser: transaction structs, parser phases,
// result kinds and status/meta codes. No dependencies.

package mtep_pkg;

    // Default longest variable-length quantity, in bytes
    localparam int VLQ_MAX_BYTES_DEF = 4;

    // Count width that holds any legal quantity length
    localparam int VLQ_CNT_W = 3;

    // Number of meta payload bytes folded into a value
    localparam logic [2:0] VALUE_BYTES = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_CHANNEL  = 3'd0;
    localparam logic [2:0] KIND_META_VAL = 3'd1;
    localparam logic [2:0] KIND_TEXT_HDR = 3'd2;
    localparam logic [2:0] KIND_TEXT_BYT = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    // Status bytes
    localparam logic [7:0] STATUS_SYS_BASE = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [3:0] HI_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] HI_CH_PRESSURE  = 4'hD;

    // Meta types
    localparam logic [7:0] META_SEQ_NUM    = 8'h00;
    localparam logic [7:0] META_CH_PREFIX  = 8'h20;
    localparam logic [7:0] META_END_TRACK  = 8'h2F;
    localparam logic [7:0] META_TEMPO      = 8'h51;
    localparam logic [7:0] META_SMPTE      = 8'h54;
    localparam logic [7:0] META_TIME_SIG   = 8'h58;
    localparam logic [7:0] META_KEY_SIG    = 8'h59;

    // Parser phases
    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_XLEN,
        PH_SKIP,
        PH_VALUE,
        PH_TEXT
    } t_phase;

    // Variable-length quantity decoder state
    typedef struct packed {
        logic [27:0]          acc;
        logic [VLQ_CNT_W-1:0] count;
    } t_vlq;

    // Input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta_time;
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [31:0] meta_value;
        logic [27:0] meta_length;
        logic [7:0]  text_byte;
        logic        last;
    } t_out;

endpackage

// ===== hw/rtl/mtep_vlq.sv =====
// One step of the variable-length quantity decoder (7 bits per byte).
// Depends on mtep_pkg.

module mtep_vlq #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  mtep_pkg::t_vlq i_state,
    input  logic [7:0]     i_byte,
    output mtep_pkg::t_vlq o_state,
    output logic           o_done
);
    import mtep_pkg::*;

    // Shift in seven bits, keep the low 28
    assign o_state.acc   = {i_state.acc[20:0], i_byte[6:0]};
    assign o_state.count = i_state.count + VLQ_CNT_W'(1);

    // Finish on a clear continuation bit or at the byte limit
    assign o_done = !i_byte[7] || (o_state.count >= VLQ_CNT_W'(VLQ_MAX_BYTES));

endmodule

// ===== hw/rtl/mtep_core.sv =====
// Parser state and single-pass decode of one track byte into at most one result.
// Depends on mtep_pkg and mtep_vlq.

module mtep_core #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  mtep_pkg::t_in  i_item,
    output logic           o_gen,
    output mtep_pkg::t_out o_result
);
    import mtep_pkg::*;

    // Control state
    t_phase      r_phase,   n_phase;
    t_vlq        r_vlq,     n_vlq;
    logic [7:0]  r_running, n_running;
    logic        r_ended,   n_ended;
    // Payload state
    logic [27:0] r_delta,   n_delta;
    logic [7:0]  r_cur,     n_cur;
    logic [7:0]  r_first,   n_first;
    logic [27:0] r_remain,  n_remain;
    logic [31:0] r_value,   n_value;
    logic [2:0]  r_capt,    n_capt;

    // Effective state after an optional track start
    t_phase      e_phase;
    t_vlq        e_vlq;
    logic [7:0]  e_running;
    logic        e_ended;

    t_vlq        vlq_sum;
    logic        vlq_done;
    logic [7:0]  b;
    logic        work;
    logic [27:0] remain_dec;
    logic        meta_skip;
    logic        meta_val;

    function automatic logic one_data_byte(input logic [7:0] st);
        return (st[7:4] == HI_PROG_CHANGE) || (st[7:4] == HI_CH_PRESSURE);
    endfunction

    assign b          = i_item.data_byte;
    assign e_phase    = i_item.track_start ? PH_DELTA : r_phase;
    assign e_vlq      = i_item.track_start ? '0 : r_vlq;
    assign e_running  = i_item.track_start ? 8'h00 : r_running;
    assign e_ended    = i_item.track_start ? 1'b0 : r_ended;
    assign work       = i_accept && !e_ended;
    assign remain_dec = r_remain - 28'd1;
    assign meta_skip  = (r_first == META_SEQ_NUM) || (r_first == META_CH_PREFIX)
                     || (r_first == META_SMPTE);
    assign meta_val   = (r_first == META_TEMPO) || (r_first == META_TIME_SIG)
                     || (r_first == META_KEY_SIG);

    mtep_vlq #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_vlq (
        .i_state (e_vlq),
        .i_byte  (b),
        .o_state (vlq_sum),
        .o_done  (vlq_done)
    );

    // Next state
    always_comb begin
        n_phase   = i_accept ? e_phase   : r_phase;
        n_vlq     = i_accept ? e_vlq     : r_vlq;
        n_running = i_accept ? e_running : r_running;
        n_ended   = i_accept ? e_ended   : r_ended;
        n_delta   = r_delta;
        n_cur     = r_cur;
        n_first   = r_first;
        n_remain  = r_remain;
        n_value   = r_value;
        n_capt    = r_capt;
        if (work) begin
            unique case (e_phase)
                PH_DELTA: begin
                    n_vlq = vlq_sum;
                    if (vlq_done) begin
                        n_delta = vlq_sum.acc;
                        n_vlq   = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!b[7]) begin
                        if (e_running == 8'h00) begin
                            n_cur   = 8'h00;
                            n_phase = PH_DELTA;
                        end else begin
                            n_cur   = e_running;
                            n_first = b;
                            n_phase = one_data_byte(e_running) ? PH_DELTA : PH_DATA2;
                        end
                    end else begin
                        n_cur = b;
                        if (b < STATUS_SYS_BASE) begin
                            n_running = b;
                            n_phase   = PH_DATA1;
                        end else begin
                            n_running = 8'h00;
                            if (b == STATUS_META) begin
                                n_phase = PH_MTYPE;
                            end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_CT) begin
                                n_phase = PH_XLEN;
                            end else begin
                                n_phase = PH_DELTA;
                            end
                        end
                    end
                end
                PH_DATA1: begin
                    n_first = b;
                    n_phase = one_data_byte(r_cur) ? PH_DELTA : PH_DATA2;
                end
                PH_DATA2: begin
                    n_phase = PH_DELTA;
                end
                PH_MTYPE: begin
                    n_first = b;
                    n_phase = PH_MLEN;
                end
                PH_MLEN: begin
                    n_vlq = vlq_sum;
                    if (vlq_done) begin
                        n_vlq    = '0;
                        n_remain = vlq_sum.acc;
                        n_value  = 32'd0;
                        n_capt   = 3'd0;
                        if (meta_skip) begin
                            n_phase = (vlq_sum.acc == 28'd0) ? PH_DELTA : PH_SKIP;
                        end else if (r_first == META_END_TRACK) begin
                            n_ended = 1'b1;
                            n_phase = PH_DELTA;
                        end else if (meta_val) begin
                            n_phase = (vlq_sum.acc == 28'd0) ? PH_DELTA : PH_VALUE;
                        end else begin
                            n_phase = (vlq_sum.acc == 28'd0) ? PH_DELTA : PH_TEXT;
                        end
                    end
                end
                PH_XLEN: begin
                    n_vlq = vlq_sum;
                    if (vlq_done) begin
                        n_vlq    = '0;
                        n_remain = vlq_sum.acc;
                        n_phase  = (vlq_sum.acc == 28'd0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_SKIP, PH_TEXT: begin
                    n_remain = remain_dec;
                    if (remain_dec == 28'd0) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_VALUE: begin
                    if (r_capt < VALUE_BYTES) begin
                        n_value = {r_value[23:0], b};
                        n_capt  = r_capt + 3'd1;
                    end
                    n_remain = remain_dec;
                    if (remain_dec == 28'd0) begin
                        n_phase = PH_DELTA;
                    end
                end
                default: begin
                    n_phase = PH_DELTA;
                end
            endcase
        end
    end

    // Result for this byte
    always_comb begin
        o_gen               = 1'b0;
        o_result            = '0;
        o_result.delta_time = n_delta;
        o_result.status     = n_cur;
        o_result.last       = 1'b1;
        if (work) begin
            unique case (e_phase)
                PH_STATUS: begin
                    if (!b[7]) begin
                        o_gen          = (e_running == 8'h00) || one_data_byte(e_running);
                        o_result.kind  = (e_running == 8'h00) ? KIND_ERROR : KIND_CHANNEL;
                        o_result.data1 = b;
                    end else begin
                        o_gen = (b >= STATUS_SYS_BASE) && (b != STATUS_META)
                             && (b != STATUS_SYSEX) && (b != STATUS_SYSEX_CT);
                        o_result.kind = KIND_ERROR;
                    end
                end
                PH_DATA1: begin
                    o_gen          = one_data_byte(r_cur);
                    o_result.kind  = KIND_CHANNEL;
                    o_result.data1 = b;
                end
                PH_DATA2: begin
                    o_gen          = 1'b1;
                    o_result.kind  = KIND_CHANNEL;
                    o_result.data1 = r_first;
                    o_result.data2 = b;
                end
                PH_MLEN: begin
                    o_result.data1 = r_first;
                    if (vlq_done && !meta_skip) begin
                        o_gen = 1'b1;
                        if (r_first == META_END_TRACK) begin
                            o_result.kind        = KIND_END;
                            o_result.meta_length = vlq_sum.acc;
                        end else if (meta_val) begin
                            o_gen         = (vlq_sum.acc == 28'd0);
                            o_result.kind = KIND_META_VAL;
                        end else begin
                            o_result.kind        = KIND_TEXT_HDR;
                            o_result.meta_length = vlq_sum.acc;
                            o_result.last        = (vlq_sum.acc == 28'd0);
                        end
                    end
                end
                PH_VALUE: begin
                    o_gen               = (remain_dec == 28'd0);
                    o_result.kind       = KIND_META_VAL;
                    o_result.data1      = r_first;
                    o_result.meta_value = n_value;
                end
                PH_TEXT: begin
                    o_gen              = 1'b1;
                    o_result.kind      = KIND_TEXT_BYT;
                    o_result.data1     = r_first;
                    o_result.text_byte = b;
                    o_result.last      = (remain_dec == 28'd0);
                end
                default: begin
                    o_gen = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_DELTA;
            r_vlq     <= '0;
            r_running <= 8'h00;
            r_ended   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_vlq     <= n_vlq;
            r_running <= n_running;
            r_ended   <= n_ended;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_delta  <= n_delta;
        r_cur    <= n_cur;
        r_first  <= n_first;
        r_remain <= n_remain;
        r_value  <= n_value;
        r_capt   <= n_capt;
    end

    a_ended_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> (r_phase == PH_DELTA))
        else $error("ended track left parser out of delta phase");

    a_vlq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vlq.count < VLQ_CNT_W'(VLQ_MAX_BYTES))
        else $error("quantity byte count passed its limit");

    a_remain_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP || r_phase == PH_TEXT || r_phase == PH_VALUE)
            |-> (r_remain != 28'd0))
        else $error("payload phase entered with nothing left");

endmodule

// ===== hw/rtl/mtep_outbuf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on mtep_pkg.

module mtep_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_gen,
    input  mtep_pkg::t_out i_result,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output mtep_pkg::t_out o_result
);
    import mtep_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic take;

    assign take     = r_out_valid && !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !take) begin
            r_skid_valid <= i_gen;
        end else begin
            r_out_valid <= i_gen;
        end
    end

    // Move payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid && !take) begin
            if (i_gen) begin
                r_skid <= i_result;
            end
        end else if (i_gen) begin
            r_out <= i_result;
        end
    end

    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid entry not drained after transaction");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_gen && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("result lost while output stalled");

endmodule

// ===== hw/rtl/midi_track_event_parser.sv =====
// MIDI track event parser: one track byte in per cycle while o_stall is low, at most
// one result out. Each result is registered in the output register, or in the skid
// register while the output is stalled. o_stall rises only when two results are
// buffered, which the two-entry output buffer allows only under downstream stall.
// Reset (synchronous, active low) clears parser phase, running status and buffer.
// Depends on mtep_pkg, mtep_core, mtep_vlq and mtep_outbuf.

module midi_track_event_parser #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mtep_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output mtep_pkg::t_out o_result
);
    import mtep_pkg::*;

    logic accept;
    logic gen;
    logic full;
    t_out result;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    mtep_core #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_gen    (gen),
        .o_result (result)
    );

    mtep_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gen    (gen),
        .i_result (result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// ===== verif/tb_midi_track_event_parser.sv =====
// Testbench for midi_track_event_parser: streams directed and random MIDI track bytes,
// predicts every result in a local parser model and checks it against the block.
// Depends on mtep_pkg and the midi_track_event_parser RTL.

module tb_midi_track_event_parser;

    import mtep_pkg::*;

    localparam int          VLQ_LIMIT   = VLQ_MAX_BYTES_DEF;
    localparam int          STUCK_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 64;
    localparam int          PHASE_BYTES = 120;
    localparam logic [7:0]  NO_RUNNING  = 8'h00;
    localparam logic [7:0]  NOTE_ON     = 8'h90;
    localparam logic [7:0]  PROG_CH5    = 8'hC5;
    localparam logic [7:0]  BAD_STATUS  = 8'hF5;
    localparam logic [7:0]  META_TEXT   = 8'h01;
    localparam logic [7:0]  META_NAME   = 8'h03;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_item  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_result;

    midi_track_event_parser u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Stimulus and scoreboard storage
    t_in  pending_bytes [$];
    t_out expected_events [$];
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   hold_request   = 1'b0;
    int   failures       = 0;
    int   stuck_cycles   = 0;

    // Parser shadow state
    t_phase      p_phase;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_cnt;
    logic [27:0] ev_delta;
    logic [7:0]  run_status;
    logic [7:0]  cur_status;
    logic [7:0]  first_byte;
    logic [27:0] bytes_left;
    logic [31:0] meta_val;
    logic [2:0]  val_cnt;
    logic        ended;

    // Generator state
    logic       new_track = 1'b0;
    logic [7:0] gen_run   = 8'h00;

    function automatic void clear_parser();
        p_phase    = PH_DELTA;
        vlq_acc    = '0;
        vlq_cnt    = '0;
        ev_delta   = '0;
        run_status = NO_RUNNING;
        cur_status = '0;
        first_byte = '0;
        bytes_left = '0;
        meta_val   = '0;
        val_cnt    = '0;
        ended      = 1'b0;
    endfunction

    // Shift one byte into the length decoder; report when the quantity is complete
    function automatic bit vlq_step(input logic [7:0] b);
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        return !b[7] || (vlq_cnt >= VLQ_LIMIT);
    endfunction

    function automatic bit one_data(input logic [7:0] st);
        return st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CH_PRESSURE;
    endfunction

    function automatic t_out make_result(input logic [2:0] kind, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [31:0] val,
                                         input logic [27:0] len, input logic [7:0] txt,
                                         input logic last);
        t_out r;
        r.kind        = kind;
        r.delta_time  = ev_delta;
        r.status      = cur_status;
        r.data1       = d1;
        r.data2       = d2;
        r.meta_value  = val;
        r.meta_length = len;
        r.text_byte   = txt;
        r.last        = last;
        return r;
    endfunction

    // Advance the shadow parser by one byte; return 1 with the event it yields
    function automatic bit parse_byte(input t_in item, output t_out res);
        logic [7:0]  b;
        logic [27:0] qty;
        b   = item.data_byte;
        res = '0;
        if (item.track_start) clear_parser();
        if (ended) return 1'b0;
        case (p_phase)
            PH_DELTA: begin
                if (vlq_step(b)) begin
                    ev_delta = vlq_acc;
                    vlq_acc  = '0;
                    vlq_cnt  = '0;
                    p_phase  = PH_STATUS;
                end
                return 1'b0;
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_status == NO_RUNNING) begin
                        cur_status = '0;
                        p_phase    = PH_DELTA;
                        res = make_result(KIND_ERROR, b, '0, '0, '0, '0, 1'b1);
                        return 1'b1;
                    end
                    cur_status = run_status;
                    first_byte = b;
                    if (one_data(cur_status)) begin
                        p_phase = PH_DELTA;
                        res = make_result(KIND_CHANNEL, b, '0, '0, '0, '0, 1'b1);
                        return 1'b1;
                    end
                    p_phase = PH_DATA2;
                    return 1'b0;
                end
                cur_status = b;
                if (b < STATUS_SYS_BASE) begin
                    run_status = b;
                    p_phase    = PH_DATA1;
                    return 1'b0;
                end
                run_status = NO_RUNNING;
                if (b == STATUS_META) begin
                    p_phase = PH_MTYPE;
                    return 1'b0;
                end
                if (b == STATUS_SYSEX || b == STATUS_SYSEX_CT) begin
                    p_phase = PH_XLEN;
                    return 1'b0;
                end
                p_phase = PH_DELTA;
                res = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b1);
                return 1'b1;
            end
            PH_DATA1: begin
                first_byte = b;
                if (one_data(cur_status)) begin
                    p_phase = PH_DELTA;
                    res = make_result(KIND_CHANNEL, b, '0, '0, '0, '0, 1'b1);
                    return 1'b1;
                end
                p_phase = PH_DATA2;
                return 1'b0;
            end
            PH_DATA2: begin
                p_phase = PH_DELTA;
                res = make_result(KIND_CHANNEL, first_byte, b, '0, '0, '0, 1'b1);
                return 1'b1;
            end
            PH_MTYPE: begin
                first_byte = b;
                p_phase    = PH_MLEN;
                return 1'b0;
            end
            PH_MLEN: begin
                if (!vlq_step(b)) return 1'b0;
                qty        = vlq_acc;
                vlq_acc    = '0;
                vlq_cnt    = '0;
                bytes_left = qty;
                meta_val   = '0;
                val_cnt    = '0;
                if (first_byte == META_SEQ_NUM || first_byte == META_CH_PREFIX ||
                    first_byte == META_SMPTE) begin
                    p_phase = (qty == 0) ? PH_DELTA : PH_SKIP;
                    return 1'b0;
                end
                if (first_byte == META_END_TRACK) begin
                    ended   = 1'b1;
                    p_phase = PH_DELTA;
                    res = make_result(KIND_END, first_byte, '0, '0, qty, '0, 1'b1);
                    return 1'b1;
                end
                if (first_byte == META_TEMPO || first_byte == META_TIME_SIG ||
                    first_byte == META_KEY_SIG) begin
                    if (qty == 0) begin
                        p_phase = PH_DELTA;
                        res = make_result(KIND_META_VAL, first_byte, '0, '0, '0, '0, 1'b1);
                        return 1'b1;
                    end
                    p_phase = PH_VALUE;
                    return 1'b0;
                end
                p_phase = (qty == 0) ? PH_DELTA : PH_TEXT;
                res = make_result(KIND_TEXT_HDR, first_byte, '0, '0, qty, '0, qty == 0);
                return 1'b1;
            end
            PH_XLEN: begin
                if (!vlq_step(b)) return 1'b0;
                bytes_left = vlq_acc;
                vlq_acc    = '0;
                vlq_cnt    = '0;
                p_phase    = (bytes_left == 0) ? PH_DELTA : PH_SKIP;
                return 1'b0;
            end
            PH_SKIP: begin
                bytes_left = bytes_left - 28'd1;
                if (bytes_left == 0) p_phase = PH_DELTA;
                return 1'b0;
            end
            PH_VALUE: begin
                // fold the first four payload bytes, drop the rest
                if (val_cnt < VALUE_BYTES) begin
                    meta_val = {meta_val[23:0], b};
                    val_cnt  = val_cnt + 3'd1;
                end
                bytes_left = bytes_left - 28'd1;
                if (bytes_left != 0) return 1'b0;
                p_phase = PH_DELTA;
                res = make_result(KIND_META_VAL, first_byte, '0, meta_val, '0, '0, 1'b1);
                return 1'b1;
            end
            PH_TEXT: begin
                bytes_left = bytes_left - 28'd1;
                if (bytes_left == 0) p_phase = PH_DELTA;
                res = make_result(KIND_TEXT_BYT, first_byte, '0, '0, '0, b, bytes_left == 0);
                return 1'b1;
            end
            default: begin
                p_phase = PH_DELTA;
                return 1'b0;
            end
        endcase
    endfunction

    // Byte stream construction
    task automatic push_byte(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), t_in'{b, new_track});
        new_track = 1'b0;
    endtask

    task automatic push_qty(input int unsigned v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--)
            push_byte(8'(((v >> (7 * i)) & 127) | (i != 0 ? 128 : 0)));
    endtask

    task automatic push_payload(input int n);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] data_value();
        return 8'(($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                               : $urandom_range(0, 127));
    endfunction

    // Delta time: mostly short, sometimes full width, sometimes overlong
    task automatic push_delta();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 1 : (r < 80) ? $urandom_range(2, 3) : 4;
        for (int i = n - 1; i >= 0; i--)
            push_byte(8'($urandom_range(0, 127) | ((i != 0 || r >= 93) ? 128 : 0)));
    endtask

    function automatic bit special_meta(input logic [7:0] t);
        return t == META_SEQ_NUM || t == META_CH_PREFIX || t == META_END_TRACK ||
               t == META_TEMPO || t == META_SMPTE || t == META_TIME_SIG || t == META_KEY_SIG;
    endfunction

    task automatic gen_event();
        int r, len;
        logic [7:0] st, mtype;
        if ($urandom_range(0, 49) == 0) new_track = 1'b1;
        if (new_track) gen_run = NO_RUNNING;
        r = $urandom_range(0, 99);
        // stray byte with no delta in front of it
        if (r < 3) begin
            push_byte(8'($urandom_range(0, 255)));
            return;
        end
        push_delta();
        if (r < 33) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            gen_run = st;
            push_byte(st);
            push_byte(data_value());
            if (!one_data(st)) push_byte(data_value());
        end else if (r < 53) begin
            push_byte(data_value() & 8'h7F);
            if (gen_run != NO_RUNNING && !one_data(gen_run)) push_byte(data_value());
        end else if (r < 63) begin
            case ($urandom_range(0, 2))
                0:       mtype = META_TEMPO;
                1:       mtype = META_TIME_SIG;
                default: mtype = META_KEY_SIG;
            endcase
            len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 7);
            gen_run = NO_RUNNING;
            push_byte(STATUS_META);
            push_byte(mtype);
            push_qty(len);
            push_payload(len);
        end else if (r < 73) begin
            do mtype = 8'($urandom_range(0, 255)); while (special_meta(mtype));
            gen_run = NO_RUNNING;
            push_byte(STATUS_META);
            push_byte(mtype);
            case ($urandom_range(0, 19))
                0: begin
                    // huge text cut short by a new track
                    push_qty($urandom_range(1 << 21, 28'hFFFFFFF));
                    push_payload($urandom_range(1, 3));
                    new_track = 1'b1;
                end
                1, 2: begin
                    len = $urandom_range(128, 150);
                    push_qty(len);
                    push_payload(len);
                end
                default: begin
                    len = $urandom_range(0, 5);
                    push_qty(len);
                    push_payload(len);
                end
            endcase
        end else if (r < 79) begin
            case ($urandom_range(0, 2))
                0:       mtype = META_SEQ_NUM;
                1:       mtype = META_CH_PREFIX;
                default: mtype = META_SMPTE;
            endcase
            len = $urandom_range(0, 5);
            gen_run = NO_RUNNING;
            push_byte(STATUS_META);
            push_byte(mtype);
            push_qty(len);
            push_payload(len);
        end else if (r < 86) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 6);
            gen_run = NO_RUNNING;
            push_byte($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_SYSEX_CT);
            push_qty(len);
            push_payload(len);
        end else if (r < 91) begin
            do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == STATUS_SYSEX_CT);
            gen_run = NO_RUNNING;
            push_byte(st);
        end else if (r < 94) begin
            push_byte(STATUS_META);
            push_byte(META_END_TRACK);
            push_qty($urandom_range(0, 1) ? 0 : $urandom_range(0, 28'hFFFFFFF));
            push_payload($urandom_range(0, 2));
            new_track = 1'b1;
        end else begin
            push_byte(data_value());
        end
    endtask

    task automatic push_opening();
        new_track = 1'b1;
        // explicit status, then running status
        push_byte(8'h00); push_byte(NOTE_ON); push_byte(8'h3C); push_byte(8'h7F);
        push_byte(8'h00); push_byte(8'h40); push_byte(8'h00);
        // one data byte with its top bit set
        push_byte(8'h7F); push_byte(PROG_CH5); push_byte(8'h80);
        // widest delta, then a tempo value
        push_qty(28'hFFFFFFF);
        push_byte(STATUS_META); push_byte(META_TEMPO); push_byte(8'h03);
        push_byte(8'h07); push_byte(8'hA1); push_byte(8'h20);
        // overlong delta, then data with running status cancelled
        repeat (4) push_byte(8'h80);
        push_byte(8'h12);
        push_byte(8'h00); push_byte(STATUS_SYSEX); push_byte(8'h02);
        push_byte(8'h11); push_byte(8'h22);
        push_byte(8'h00); push_byte(BAD_STATUS);
        push_byte(8'h00); push_byte(STATUS_META); push_byte(META_NAME); push_byte(8'h00);
        push_byte(8'h00); push_byte(STATUS_META); push_byte(META_TEXT); push_byte(8'h02);
        push_byte(8'h41); push_byte(8'h42);
        push_byte(8'h00); push_byte(STATUS_META); push_byte(META_SEQ_NUM); push_byte(8'h02);
        push_byte(8'h00); push_byte(8'h01);
        // end of track with the widest length; the byte after it is ignored
        push_byte(8'h00); push_byte(STATUS_META); push_byte(META_END_TRACK);
        push_qty(28'hFFFFFFF);
        push_byte(8'h55);
    endtask

    task automatic fill_phase(input int target);
        new_track = 1'b1;
        while (pending_bytes.size() < target) gen_event();
    endtask

    // Driver: offer the next byte once the previous transaction is gone
    always @(posedge i_clk) begin : driver
        t_out res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_parser();
        end else begin
            if (i_valid && !o_stall) begin
                if (parse_byte(i_item, res))
                    expected_events.insert(expected_events.size(), res);
            end
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_item  <= pending_bytes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    function automatic string show(input t_out r);
        return $sformatf("kind=%0d delta=%h st=%h d1=%h d2=%h val=%h len=%h txt=%h last=%b",
                         r.kind, r.delta_time, r.status, r.data1, r.data2,
                         r.meta_value, r.meta_length, r.text_byte, r.last);
    endfunction

    task automatic report_bad(input string what, input t_out want, input t_out got);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
        end
    endtask

    // Monitor: check each accepted result, drive receiver back-pressure
    always @(posedge i_clk) begin : monitor
        t_out want;
        int   hold_left;
        bit   hold_taken;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_events.size() == 0) begin
                    report_bad("unexpected result", '0, o_result);
                end else begin
                    want = expected_events.pop_front();
                    if (o_result.kind !== want.kind || o_result.delta_time !== want.delta_time ||
                        o_result.status !== want.status || o_result.data1 !== want.data1 ||
                        o_result.data2 !== want.data2 ||
                        o_result.meta_value !== want.meta_value ||
                        o_result.meta_length !== want.meta_length ||
                        o_result.text_byte !== want.text_byte || o_result.last !== want.last)
                        report_bad("result mismatch", want, o_result);
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        push_opening();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
                3:       begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (ph == 4) hold_request = 1'b1;
            fill_phase(pending_bytes.size() + PHASE_BYTES);
            // drain every byte and every expected result before moving on
            while (pending_bytes.size() != 0 || i_valid || expected_events.size() != 0)
                @(negedge i_clk);
            repeat (4) @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (failures == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== midi_track_event_parser.f =====
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_vlq.sv
hw/rtl/mtep_core.sv
hw/rtl/mtep_outbuf.sv
hw/rtl/midi_track_event_parser.sv
verif/tb_midi_track_event_parser.sv
